@@ rtl/core/lfba_pkg.sv @@
`timescale 1ns / 1ps

package lfba_pkg;

	// Field widths
	localparam int unsigned OP_W     = 2;
	localparam int unsigned IDX_W    = 8;
	localparam int unsigned CNT_W    = 9;
	localparam int unsigned STRIDE_W = 17;
	localparam int unsigned OFFSET_W = 24;
	localparam int unsigned CFG_W    = STRIDE_W;

	// Link memory covers every index that the request word can name
	localparam int unsigned LINK_DEPTH = 1 << IDX_W;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_RESET = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_OUT_OF_MEM  = 2'd1;
	localparam logic [1:0] ST_FREE_IDLE   = 2'd2;
	localparam logic [1:0] ST_RESET_BUSY  = 2'd3;

	// Configuration register indexes
	localparam logic CFG_BLOCK_LIMIT  = 1'b0;
	localparam logic CFG_STRIDE_BYTES = 1'b1;

	// Reset values of configuration registers
	localparam logic [CNT_W-1:0]    BLOCK_LIMIT_RST  = 9'd256;
	localparam logic [STRIDE_W-1:0] STRIDE_BYTES_RST = 17'd64;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [IDX_W-1:0] block_index;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [IDX_W-1:0]    granted_index;
		logic [OFFSET_W-1:0] byte_offset;
		logic [CNT_W-1:0]    active_count;
		logic [CNT_W-1:0]    fresh_remaining;
		logic [CNT_W-1:0]    reusable_count;
	} rsp_t;

endpackage

@@ rtl/core/lfba_ram.sv @@
`timescale 1ns / 1ps

module lfba_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/lazy_free_list_block_allocator.sv @@
`timescale 1ns / 1ps

// Fixed-size block allocator over one region. Each request word is an allocate, a free,
// a reset or a no-op; each gives exactly one response word. An allocate reuses the most
// recently freed block (LIFO list whose links live in a 256-entry link RAM), else hands
// out the next fresh block from a bump counter up to min(block_limit, NUM_BLOCKS, 256),
// else reports out of memory. A free is refused while no block is active, a reset while
// any block is active. Offsets are granted_index * stride_bytes, wrapped to 24 bits.
// The accept cycle issues the link RAM read at the list head; in S_EXEC the read word is
// used to update state and the response register. The request side stalls throughout
// S_EXEC, which goes on while the response register is still full and stalled. Write
// configuration only while the block is idle.
module lazy_free_list_block_allocator #(
	parameter int unsigned NUM_BLOCKS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  lfba_pkg::req_t                      req_word,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output lfba_pkg::rsp_t                      rsp_word,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [lfba_pkg::CFG_W-1:0]          cfg_data
);

	localparam logic [lfba_pkg::CNT_W-1:0] LIM_CAP =
		(NUM_BLOCKS >= lfba_pkg::LINK_DEPTH) ? lfba_pkg::CNT_W'(lfba_pkg::LINK_DEPTH)
		                                     : lfba_pkg::CNT_W'(NUM_BLOCKS);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                           state_q;
	lfba_pkg::req_t                   req_s1;
	logic [lfba_pkg::CNT_W-1:0]       block_limit_q;
	logic [lfba_pkg::STRIDE_W-1:0]    stride_q;
	logic [lfba_pkg::CNT_W-1:0]       bump_q;
	logic [lfba_pkg::IDX_W-1:0]       head_q;
	logic                             nonempty_q;
	logic [lfba_pkg::CNT_W-1:0]       active_q;
	logic [lfba_pkg::CNT_W-1:0]       listed_q;
	logic                             rsp_valid_q;
	lfba_pkg::rsp_t                   rsp_q;

	logic [lfba_pkg::IDX_W-1:0]       link_rdata;
	logic                             link_we;

	logic [lfba_pkg::CNT_W-1:0]       lim;
	logic                             done;
	logic [1:0]                       status_d;
	logic [lfba_pkg::IDX_W-1:0]       granted_d;
	logic                             grant_ok;
	logic [lfba_pkg::CNT_W-1:0]       bump_d;
	logic [lfba_pkg::IDX_W-1:0]       head_d;
	logic                             nonempty_d;
	logic [lfba_pkg::CNT_W-1:0]       active_d;
	logic [lfba_pkg::CNT_W-1:0]       listed_d;
	logic [lfba_pkg::CNT_W-1:0]       fresh_d;
	logic [lfba_pkg::IDX_W+lfba_pkg::STRIDE_W-1:0] product;

	// Link RAM: read at the list head, written by a free
	lfba_ram #(
		.WIDTH(lfba_pkg::IDX_W),
		.DEPTH(lfba_pkg::LINK_DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(req_s1.block_index),
		.wdata(head_q),
		.raddr(head_q),
		.rdata(link_rdata)
	);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	// Finish the request once the response register can take a word
	assign done = (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);

	assign lim = (block_limit_q < LIM_CAP) ? block_limit_q : LIM_CAP;

	// Decide the outcome of the held request
	always_comb begin
		status_d   = lfba_pkg::ST_OK;
		granted_d  = '0;
		grant_ok   = 1'b0;
		bump_d     = bump_q;
		head_d     = head_q;
		nonempty_d = nonempty_q;
		active_d   = active_q;
		listed_d   = listed_q;
		link_we    = 1'b0;
		unique case (req_s1.operation)
			lfba_pkg::OP_ALLOC: begin
				if (nonempty_q) begin
					granted_d  = head_q;
					grant_ok   = 1'b1;
					head_d     = link_rdata;
					listed_d   = listed_q - 1'b1;
					nonempty_d = (listed_d != '0);
					active_d   = active_q + 1'b1;
				end else if (bump_q < lim) begin
					granted_d = bump_q[lfba_pkg::IDX_W-1:0];
					grant_ok  = 1'b1;
					bump_d    = bump_q + 1'b1;
					active_d  = active_q + 1'b1;
				end else begin
					status_d = lfba_pkg::ST_OUT_OF_MEM;
				end
			end
			lfba_pkg::OP_FREE: begin
				if (active_q == '0) begin
					status_d = lfba_pkg::ST_FREE_IDLE;
				end else begin
					link_we    = done;
					head_d     = req_s1.block_index;
					nonempty_d = 1'b1;
					listed_d   = listed_q + 1'b1;
					active_d   = active_q - 1'b1;
				end
			end
			lfba_pkg::OP_RESET: begin
				if (active_q != '0) begin
					status_d = lfba_pkg::ST_RESET_BUSY;
				end else begin
					bump_d     = '0;
					head_d     = '0;
					nonempty_d = 1'b0;
					listed_d   = '0;
				end
			end
			lfba_pkg::OP_NONE: begin
			end
			default: begin
			end
		endcase
		fresh_d = (bump_d < lim) ? (lim - bump_d) : '0;
	end

	// Offset of the granted block
	assign product = (lfba_pkg::IDX_W+lfba_pkg::STRIDE_W)'(granted_d)
	               * (lfba_pkg::IDX_W+lfba_pkg::STRIDE_W)'(stride_q);

	// Hold state, configuration and the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			block_limit_q <= lfba_pkg::BLOCK_LIMIT_RST;
			stride_q      <= lfba_pkg::STRIDE_BYTES_RST;
			bump_q        <= '0;
			head_q        <= '0;
			nonempty_q    <= 1'b0;
			active_q      <= '0;
			listed_q      <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			// Write configuration
			if (cfg_we) begin
				unique case (cfg_index)
					lfba_pkg::CFG_BLOCK_LIMIT:
						block_limit_q <= cfg_data[lfba_pkg::CNT_W-1:0];
					lfba_pkg::CFG_STRIDE_BYTES:
						stride_q <= cfg_data[lfba_pkg::STRIDE_W-1:0];
					default: begin
					end
				endcase
			end
			// Raise the response when a request finishes, drop it once taken
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (done) begin
						state_q     <= S_IDLE;
						bump_q      <= bump_d;
						head_q      <= head_d;
						nonempty_q  <= nonempty_d;
						active_q    <= active_d;
						listed_q    <= listed_d;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the request word and build the response word
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_s1 <= req_word;
		end
		if (done) begin
			rsp_q.status          <= status_d;
			rsp_q.granted_index   <= granted_d;
			rsp_q.byte_offset     <= grant_ok ? product[lfba_pkg::OFFSET_W-1:0] : '0;
			rsp_q.active_count    <= active_d;
			rsp_q.fresh_remaining <= fresh_d;
			rsp_q.reusable_count  <= listed_d;
		end
	end

endmodule
